/* design/grid_mesh_neighbor_indexer_assert.svh */
// Assertion macros for the grid mesh neighbor indexer.
`ifndef GRID_MESH_NEIGHBOR_INDEXER_ASSERT_SVH
`define GRID_MESH_NEIGHBOR_INDEXER_ASSERT_SVH

`ifndef SYNTH
`define GMNI_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define GMNI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define GMNI_ASSERT(lbl, expr, msg)
`define GMNI_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

/* design/gmni_pkg.sv */
// Shared types and constants of the grid mesh neighbor indexer.
package gmni_pkg;

  localparam int unsigned SEC_W     = 8;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned DIM_W     = 9;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned TOT_W     = 17;
  localparam int unsigned NSLOT     = 6;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SEC_W-1:0] MIN_SECTIONS = 8'd3;
  localparam logic [SEC_W-1:0] RESET_SECTIONS = 8'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_SECTIONS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_SECTIONS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_CLOSED  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_CLOSED  = 2'd3;

  // Neighbor slots in emission order
  localparam int unsigned SLOT_PREV      = 0;
  localparam int unsigned SLOT_PREV_DOWN = 1;
  localparam int unsigned SLOT_DOWN      = 2;
  localparam int unsigned SLOT_NEXT      = 3;
  localparam int unsigned SLOT_NEXT_UP   = 4;
  localparam int unsigned SLOT_UP        = 5;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [TOT_W-1:0] total;
    logic [TOT_W-1:0] total_m_cols;
    logic             rows_closed;
    logic             cols_closed;
    logic             mesh_ok;
  } cfg_t;

  typedef struct packed {
    logic             bad;
    logic [NSLOT-1:0] mask;
    logic [ID_W-1:0]  vid;
    logic [ID_W-1:0]  pid;
    logic [ID_W-1:0]  nid;
  } entry_t;

endpackage

/* design/gmni_in_if.sv */
// Input channel: one vertex position per word.
interface gmni_in_if;
  import gmni_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] row_pos;
  logic [POS_W-1:0] col_pos;
  modport source (output valid, row_pos, col_pos, input ready);
  modport sink (input valid, row_pos, col_pos, output ready);
endinterface

/* design/gmni_out_if.sv */
// Output channel: one neighbor index per word.
interface gmni_out_if;
  import gmni_pkg::*;
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] vertex_id;
  logic [ID_W-1:0] neighbor_id;
  logic            last_neighbor;
  logic            bad_position;
  modport source (output valid, vertex_id, neighbor_id, last_neighbor, bad_position,
                  input ready);
  modport sink (input valid, vertex_id, neighbor_id, last_neighbor, bad_position,
                output ready);
endinterface

/* design/grid_mesh_neighbor_indexer.sv */
// A position accepted by the front end is registered there, then written into the queue,
// then loaded into the output register, from which the sink takes its first neighbor word.
// Throughput: one result word per cycle while the sink is ready; a vertex gives 1 to 6
// neighbor words, one per set slot (a rejected position gives one).
// A four-word queue lets the front end keep accepting while the emitter is stalled.
// Reset (asynchronous, active low) empties the pipeline and queue and loads the
// section counts with 3 and both closed flags with 0.
module grid_mesh_neighbor_indexer import gmni_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SEC_W-1:0]     cfg_data_i,
  gmni_in_if.sink              in_i,
  gmni_out_if.source           out_o
);

  logic [SEC_W-1:0] row_sec_q, col_sec_q;
  logic             rows_closed_q, cols_closed_q;
  logic [TOT_W-1:0] total_q, total_d;
  logic [TOT_W-1:0] tmc_q, tmc_d;
  logic [DIM_W-1:0] rows, cols;
  cfg_t             cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_sec_q     <= RESET_SECTIONS;
      col_sec_q     <= RESET_SECTIONS;
      rows_closed_q <= 1'b0;
      cols_closed_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW_SECTIONS: row_sec_q     <= cfg_data_i;
        CFG_COL_SECTIONS: col_sec_q     <= cfg_data_i;
        CFG_ROWS_CLOSED:  rows_closed_q <= cfg_data_i[0];
        CFG_COLS_CLOSED:  cols_closed_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rows    = DIM_W'(row_sec_q) + DIM_W'(!rows_closed_q);
    cols    = DIM_W'(col_sec_q) + DIM_W'(!cols_closed_q);
    total_d = TOT_W'(rows) * TOT_W'(cols);
    tmc_d   = total_q - TOT_W'(cols);
  end

  // Derived sizes: the total is registered from the section counts, then total minus cols from it
  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    tmc_q   <= tmc_d;
  end

  always_comb begin
    cfg.rows         = rows;
    cfg.cols         = cols;
    cfg.total        = total_q;
    cfg.total_m_cols = tmc_q;
    cfg.rows_closed  = rows_closed_q;
    cfg.cols_closed  = cols_closed_q;
    cfg.mesh_ok      = (row_sec_q >= MIN_SECTIONS) && (col_sec_q >= MIN_SECTIONS);
  end

  entry_t f_ent, q_head;
  logic   f_valid, f_ready, q_valid, q_pop;

  gmni_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .ent_o       (f_ent),
    .ent_valid_o (f_valid),
    .ent_ready_i (f_ready)
  );

  gmni_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (f_ent),
    .out_valid_o (q_valid),
    .out_ready_i (q_pop),
    .out_data_o  (q_head)
  );

  gmni_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_i       (q_head),
    .head_valid_i (q_valid),
    .head_pop_o   (q_pop),
    .out_o        (out_o)
  );

endmodule

/* design/gmni_front.sv */
// Front end: accept positions, range check, row base and neighbor slot mask.
module gmni_front import gmni_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  gmni_in_if.sink in_i,
  output entry_t ent_o,
  output logic   ent_valid_o,
  input  logic   ent_ready_i
);

  logic             s1_valid_q;
  logic [POS_W-1:0] s_q, s_d;
  logic [POS_W-1:0] t_q, t_d;
  logic             bad_q, bad_d;
  logic [ID_W-1:0]  rb_q, rb_d;
  logic [TOT_W-1:0] prod;
  logic             advance;

  assign advance    = !s1_valid_q || ent_ready_i;
  assign in_i.ready = advance;

  always_comb begin
    s_d   = in_i.row_pos;
    t_d   = in_i.col_pos;
    bad_d = !cfg_i.mesh_ok || ({1'b0, in_i.row_pos} >= cfg_i.rows) ||
            ({1'b0, in_i.col_pos} >= cfg_i.cols);
    prod  = TOT_W'(in_i.row_pos) * TOT_W'(cfg_i.cols);
    rb_d  = prod[ID_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_i.valid) begin
      s_q   <= s_d;
      t_q   <= t_d;
      bad_q <= bad_d;
      rb_q  <= rb_d;
    end
  end

  // Classify borders and build the queue word
  logic             t_first, t_last, s_first, s_last;
  logic             has_prev, has_next, has_down, has_up;
  logic [DIM_W-1:0] t9, pcol, ncol;

  always_comb begin
    t9       = {1'b0, t_q};
    t_first  = (t_q == '0);
    t_last   = (t9 == cfg_i.cols - DIM_W'(1));
    s_first  = (s_q == '0);
    s_last   = ({1'b0, s_q} == cfg_i.rows - DIM_W'(1));
    has_prev = !t_first || cfg_i.cols_closed;
    has_next = !t_last || cfg_i.cols_closed;
    has_down = !s_last || cfg_i.rows_closed;
    has_up   = !s_first || cfg_i.rows_closed;
    pcol     = t_first ? cfg_i.cols - DIM_W'(1) : t9 - DIM_W'(1);
    ncol     = t_last ? '0 : t9 + DIM_W'(1);

    ent_o.bad = bad_q;
    ent_o.vid = rb_q + ID_W'(t_q);
    ent_o.pid = rb_q + ID_W'(pcol);
    ent_o.nid = rb_q + ID_W'(ncol);
    ent_o.mask                 = '0;
    ent_o.mask[SLOT_PREV]      = has_prev;
    ent_o.mask[SLOT_PREV_DOWN] = has_prev && has_down;
    ent_o.mask[SLOT_DOWN]      = has_down;
    ent_o.mask[SLOT_NEXT]      = has_next;
    ent_o.mask[SLOT_NEXT_UP]   = has_next && has_up;
    ent_o.mask[SLOT_UP]        = has_up;
    // A rejected position gives a single flagged word
    if (bad_q) begin
      ent_o.mask            = '0;
      ent_o.mask[SLOT_PREV] = 1'b1;
    end
  end

  assign ent_valid_o = s1_valid_q;

endmodule

/* design/gmni_fifo.sv */
// Short queue between the front end and the emitter.
module gmni_fifo import gmni_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  entry_t in_data_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output entry_t out_data_o
);

  entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              push, pop;

  assign in_ready_o  = (count_q != (QPTR_W+1)'(QDEPTH));
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (push && !pop) begin
        count_q <= count_q + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

/* design/gmni_back.sv */
// Emitter: walk the slot mask of the head word, one neighbor index a cycle while the sink is ready.
module gmni_back import gmni_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  entry_t head_i,
  input  logic   head_valid_i,
  output logic   head_pop_o,
  gmni_out_if.source out_o
);

  `include "grid_mesh_neighbor_indexer_assert.svh"

  logic [NSLOT-1:0] done_q;
  logic [NSLOT-1:0] rem, sel;
  logic             last, load;
  logic [ID_W-1:0]  base;
  logic [TOT_W-1:0] off;
  logic [TOT_W:0]   sum, red;

  logic             out_valid_q;
  logic [ID_W-1:0]  vid_q, nid_q;
  logic             last_q, bad_q;

  always_comb begin
    rem  = head_i.mask & ~done_q;
    sel  = rem & (~rem + NSLOT'(1));
    last = ((rem & ~sel) == '0);
    load = head_valid_i && (!out_valid_q || out_o.ready);

    base = head_i.vid;
    if (sel[SLOT_PREV] || sel[SLOT_PREV_DOWN]) begin
      base = head_i.pid;
    end else if (sel[SLOT_NEXT] || sel[SLOT_NEXT_UP]) begin
      base = head_i.nid;
    end

    off = '0;
    if (sel[SLOT_PREV_DOWN] || sel[SLOT_DOWN]) begin
      off = TOT_W'(cfg_i.cols);
    end else if (sel[SLOT_NEXT_UP] || sel[SLOT_UP]) begin
      off = cfg_i.total_m_cols;
    end

    // Wrap the row step modulo the vertex count
    sum = (TOT_W+1)'(base) + (TOT_W+1)'(off);
    red = (sum >= (TOT_W+1)'(cfg_i.total)) ? sum - (TOT_W+1)'(cfg_i.total) : sum;
  end

  assign head_pop_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        done_q      <= last ? '0 : (done_q | sel);
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      vid_q  <= head_i.bad ? '0 : head_i.vid;
      nid_q  <= head_i.bad ? '0 : red[ID_W-1:0];
      last_q <= last;
      bad_q  <= head_i.bad;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.vertex_id     = vid_q;
  assign out_o.neighbor_id   = nid_q;
  assign out_o.last_neighbor = last_q;
  assign out_o.bad_position  = bad_q;

  `GMNI_ASSERT_IMPL(a_bad_single, out_valid_q && bad_q, last_q && vid_q == '0 && nid_q == '0, "bad word not a lone zero word")
  `GMNI_ASSERT_IMPL(a_head_has_work, head_valid_i, rem != '0, "head word with no slot left")
  `GMNI_ASSERT_IMPL(a_pop_on_last, head_pop_o, load && (rem & ~sel) == '0, "head dropped before last slot")

endmodule
